### rtl/nll_pkg.sv
package nll_pkg;

    // Default width of the byte position counter
    localparam int POS_BITS_DEF = 16;

    // Saturation limit of the 16-bit counts
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Result queue depth and its fill count width
    localparam int Q_DEPTH   = 4;
    localparam int QCNT_BITS = $clog2(Q_DEPTH + 1);

    // Characters the scanner looks for
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_US = 8'h5F;  // underscore
    localparam logic [7:0] CH_LX = 8'h78;  // x
    localparam logic [7:0] CH_LB = 8'h62;  // b
    localparam logic [7:0] CH_D0 = 8'h30;  // 0
    localparam logic [7:0] CH_D1 = 8'h31;  // 1
    localparam logic [7:0] CH_D9 = 8'h39;  // 9
    localparam logic [7:0] CH_LA = 8'h61;  // a
    localparam logic [7:0] CH_LF_HEX = 8'h66;  // f
    localparam logic [7:0] CH_UA = 8'h41;  // A
    localparam logic [7:0] CH_UF = 8'h46;  // F

    // Scanner mode
    typedef enum logic [2:0] {
        M_IDLE      = 3'd0,
        M_PFX_HEX   = 3'd1,
        M_PFX_BIN   = 3'd2,
        M_HEX_START = 3'd3,
        M_HEX       = 3'd4,
        M_BIN_START = 3'd5,
        M_BIN       = 3'd6,
        M_DEC       = 3'd7
    } t_mode;

    // Token kind reported with each result
    typedef enum logic [2:0] {
        K_HEX       = 3'd0,
        K_BIN       = 3'd1,
        K_DEC       = 3'd2,
        K_ERR_DUP   = 3'd3,
        K_ERR_START = 3'd4
    } t_kind;

    // One result transaction
    typedef struct packed {
        t_kind       kind;
        logic [15:0] col;
        logic [15:0] line;
        logic [15:0] dig;
        logic [15:0] len;
        logic [15:0] start;
        logic        last;
    } t_result;

    // Results handed from the scanner to the queue together
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

### rtl/numeric_literal_lexer.sv
// Number literal finder for a byte stream of source text.
// Input stream: one source byte per transaction on i_s_tdata, i_s_tlast on the
// last byte of a source. Output stream: one token per transaction, kind on
// o_m_tuser, position and counts on o_m_tdata, o_m_tlast on the last token
// caused by one input byte. i_cfg_we/i_cfg_wdata write the halt-on-bad-hex-start
// flag (reset value 1); write it only while the stream is quiet, the block does not check.
// Each byte is resolved once the byte after it arrives, so a token ended by
// byte n shows up after byte n+1 (or byte n itself when it carries tlast) is
// taken. o_m_tvalid rises once that byte has sat in the input register and the
// scanner, when the queue has room, has written its result into the result queue.
// Throughput is one byte per cycle while the queue has room. A byte that yields
// two tokens puts both in a four-entry result queue that drains one per cycle
// while i_m_tready is high; the input stalls while the queue holds more than two
// tokens, so a stalled receiver backs up into o_s_tready and nothing is lost.
// Reset clears the scanner, line and position counters and the queue, and sets
// the configuration flag to 1. After tlast all scanner state returns to reset.
module numeric_literal_lexer
    import nll_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // lead_pos, token_len, digit_count, line_number, column
    output logic [2:0]  o_m_tuser,   // token_kind
    output logic        o_m_tlast
);

    t_push   push;
    logic    room;
    t_result res;

    nll_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (i_s_tvalid),
        .o_tready    (o_s_tready),
        .i_tbyte     (i_s_tdata),
        .i_tlast     (i_s_tlast),
        .i_room      (room),
        .o_push      (push)
    );

    nll_rq u_rq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_res    (res)
    );

    // Pack the head result onto the output stream
    assign o_m_tdata = {res.col, res.line, res.dig, res.len, res.start};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.last;

endmodule

### rtl/nll_scan.sv
module nll_scan
    import nll_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_tvalid,
    output logic       o_tready,
    input  logic [7:0] i_tbyte,
    input  logic       i_tlast,
    input  logic       i_room,
    output t_push      o_push
);

    typedef struct packed {
        t_mode               mode;
        logic [7:0]          held;
        logic                held_v;
        logic [POS_BITS-1:0] bpos;
        logic [15:0]         line;
        logic [POS_BITS:0]   nlpos;
        logic                crlf;
        logic                prior_cr;
        logic [POS_BITS-1:0] tstart;
        logic [15:0]         tlen;
        logic [15:0]         tdig;
        logic                halted;
    } t_state;

    typedef struct packed {
        t_state  st;
        logic    rv;
        t_result res;
    } t_step;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_cfg;
    t_state     r_st;
    t_state     n_st;
    logic       fire;

    function automatic t_state f_clear();
        t_state s;
        s = '0;
        s.mode = M_IDLE;
        return s;
    endfunction

    function automatic logic [15:0] f_sat_inc(logic [15:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic f_is_digit(logic [7:0] c);
        return (c >= CH_D0) && (c <= CH_D9);
    endfunction

    function automatic t_kind f_kind(t_mode m);
        t_kind k;
        case (m)
            M_PFX_HEX, M_HEX_START, M_HEX: k = K_HEX;
            M_PFX_BIN, M_BIN_START, M_BIN: k = K_BIN;
            default:                       k = K_DEC;
        endcase
        return k;
    endfunction

    function automatic logic f_fits(t_mode m, logic [7:0] c);
        logic ok;
        if (c == CH_US) begin
            ok = 1'b1;
        end else if (m == M_BIN_START || m == M_BIN) begin
            ok = (c == CH_D0) || (c == CH_D1);
        end else if (f_is_digit(c)) begin
            ok = 1'b1;
        end else if (m == M_DEC) begin
            ok = 1'b0;
        end else begin
            ok = ((c >= CH_LA) && (c <= CH_LF_HEX)) || ((c >= CH_UA) && (c <= CH_UF));
        end
        return ok;
    endfunction

    // Build a result from the open token's position and line
    function automatic t_result f_res(t_state s, t_kind k, logic [15:0] len,
                                      logic [15:0] dig);
        t_result             r;
        logic [POS_BITS:0]   diff;
        logic [POS_BITS+16:0] dw;
        logic [POS_BITS+15:0] sw;
        diff = {1'b0, s.tstart} - s.nlpos;
        if ({1'b0, s.tstart} >= s.nlpos) begin
            dw = {16'b0, diff};
        end else begin
            dw = '0;
        end
        sw      = {16'b0, s.tstart};
        r.kind  = k;
        r.col   = (|dw[POS_BITS+16:16]) ? CNT_MAX : dw[15:0];
        r.line  = s.line;
        r.dig   = dig;
        r.len   = len;
        r.start = sw[15:0];
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic t_state f_add(t_state s, logic [7:0] c);
        t_state o;
        o      = s;
        o.tlen = f_sat_inc(s.tlen);
        if (c != CH_US) begin
            o.tdig = f_sat_inc(s.tdig);
        end
        return o;
    endfunction

    function automatic t_state f_begin(t_state s);
        t_state o;
        o        = s;
        o.tstart = s.bpos;
        o.tlen   = 16'd1;
        o.tdig   = 16'd1;
        return o;
    endfunction

    // Byte seen outside a token: start one or count a line break
    function automatic t_state f_idle(t_state s, logic [7:0] c, logic hn, logic [7:0] nx);
        t_state o;
        o = s;
        if (c == CH_D0) begin
            o = f_begin(s);
            if (hn && nx == CH_LX) begin
                o.mode = M_PFX_HEX;
            end else if (hn && nx == CH_LB) begin
                o.mode = M_PFX_BIN;
            end else begin
                o.mode = M_DEC;
            end
        end else if (f_is_digit(c)) begin
            o      = f_begin(s);
            o.mode = M_DEC;
        end else if (c == CH_CR || c == CH_LF) begin
            if (c == CH_CR && hn && nx == CH_LF) begin
                o.crlf = 1'b1;
            end
            if (!(s.prior_cr && c == CH_LF)) begin
                o.line  = f_sat_inc(s.line);
                o.nlpos = {1'b0, s.bpos} + {{POS_BITS{1'b0}}, o.crlf};
            end
        end
        return o;
    endfunction

    // Process one byte with its lookahead
    function automatic t_step f_take(t_state s, logic [7:0] c, logic hn, logic [7:0] nx,
                                     logic cfg);
        t_step o;
        logic  fatal;
        o.st  = s;
        o.rv  = 1'b0;
        o.res = '0;
        fatal = 1'b0;
        if (!s.halted) begin
            if (s.mode == M_PFX_HEX || s.mode == M_PFX_BIN) begin
                o.st      = f_add(s, c);
                o.st.mode = (s.mode == M_PFX_HEX) ? M_HEX_START : M_BIN_START;
            end else if (s.mode != M_IDLE) begin
                if (c == CH_US && ((s.mode == M_HEX_START && cfg) || s.mode == M_BIN_START))
                begin
                    fatal = 1'b1;
                    o.res = f_res(s, K_ERR_START, 16'd0, 16'd0);
                end else if (c == CH_US && hn && nx == CH_US) begin
                    fatal = 1'b1;
                    o.res = f_res(s, K_ERR_DUP, 16'd0, 16'd0);
                end else if (f_fits(s.mode, c)) begin
                    o.st = f_add(s, c);
                    if (s.mode == M_HEX_START) begin
                        o.st.mode = M_HEX;
                    end else if (s.mode == M_BIN_START) begin
                        o.st.mode = M_BIN;
                    end
                end else begin
                    o.rv      = 1'b1;
                    o.res     = f_res(s, f_kind(s.mode), s.tlen, s.tdig);
                    o.st.mode = M_IDLE;
                    o.st      = f_idle(o.st, c, hn, nx);
                end
            end else begin
                o.st = f_idle(s, c, hn, nx);
            end
            if (fatal) begin
                o.rv        = 1'b1;
                o.st.halted = 1'b1;
                o.st.mode   = M_IDLE;
            end else begin
                o.st.prior_cr = (c == CH_CR);
                o.st.bpos     = o.st.bpos + POS_BITS'(1);
            end
        end
        return o;
    endfunction

    // Hold the input transaction until the queue has room for two results
    assign fire     = r_in_valid && i_room;
    assign o_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_tready) begin
            r_in_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_in_byte <= i_tbyte;
            r_in_last <= i_tlast;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 1'b1;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Run the held byte, then the new byte when it ends the source
    always_comb begin
        t_step   step1;
        t_step   step2;
        logic    v1;
        logic    v2;
        logic    v3;
        t_result r3;
        if (r_st.held_v) begin
            step1 = f_take(r_st, r_st.held, 1'b1, r_in_byte, r_cfg);
        end else begin
            step1.st  = r_st;
            step1.rv  = 1'b0;
            step1.res = '0;
        end
        step2 = f_take(step1.st, r_in_byte, 1'b0, 8'd0, r_cfg);
        r3    = f_res(step2.st, f_kind(step2.st.mode), step2.st.tlen, step2.st.tdig);
        v1    = step1.rv;
        v2    = r_in_last && step2.rv;
        v3    = r_in_last && !step2.st.halted && (step2.st.mode != M_IDLE);

        if (r_in_last) begin
            n_st = f_clear();
        end else begin
            n_st        = step1.st;
            n_st.held   = r_in_byte;
            n_st.held_v = 1'b1;
        end

        // Keep the first two results in order, mark the final one
        o_push.r0 = r3;
        o_push.r1 = r3;
        if (v1) begin
            o_push.r0 = step1.res;
            o_push.r1 = v2 ? step2.res : r3;
            o_push.cnt = (v2 || v3) ? 2'd2 : 2'd1;
        end else if (v2) begin
            o_push.r0  = step2.res;
            o_push.cnt = v3 ? 2'd2 : 2'd1;
        end else begin
            o_push.cnt = v3 ? 2'd1 : 2'd0;
        end
        if (o_push.cnt == 2'd2) begin
            o_push.r1.last = 1'b1;
        end else begin
            o_push.r0.last = 1'b1;
        end
        if (!fire) begin
            o_push.cnt = 2'd0;
        end
    end

    // Advance scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= f_clear();
        end else if (fire) begin
            r_st <= n_st;
        end
    end

endmodule

### rtl/nll_rq.sv
module nll_rq
    import nll_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_tvalid,
    input  logic    i_tready,
    output t_result o_res
);

    t_result              r_q [Q_DEPTH];
    t_result              n_q [Q_DEPTH];
    logic [QCNT_BITS-1:0] r_cnt;
    logic [QCNT_BITS-1:0] n_cnt;
    logic                 pop;
    logic [QCNT_BITS-1:0] cp;
    logic [QCNT_BITS-1:0] cp1;

    assign o_tvalid = (r_cnt != '0);
    assign o_res    = r_q[0];
    assign o_room   = (r_cnt <= QCNT_BITS'(Q_DEPTH - 2));

    // Shift out the head on a transaction, append new results behind the rest
    always_comb begin
        pop   = o_tvalid && i_tready;
        cp    = r_cnt - QCNT_BITS'(pop);
        cp1   = cp + QCNT_BITS'(1);
        n_cnt = cp + QCNT_BITS'(i_push.cnt);
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (pop && (i + 1 < Q_DEPTH)) begin
                n_q[i] = r_q[(i + 1) % Q_DEPTH];
            end else begin
                n_q[i] = r_q[i];
            end
            if (i_push.cnt != 2'd0 && cp == QCNT_BITS'(i)) begin
                n_q[i] = i_push.r0;
            end
            if (i_push.cnt == 2'd2 && cp1 == QCNT_BITS'(i)) begin
                n_q[i] = i_push.r1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule
